FILE: rtl/fullscreen_surface_placement_defines.svh
// assertion helpers shared by the checker
`ifndef FULLSCREEN_SURFACE_PLACEMENT_DEFINES_SVH
`define FULLSCREEN_SURFACE_PLACEMENT_DEFINES_SVH

// same-cycle implication
`define FSP_ASSERT_NOW(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("fsp assertion failed");

// next-cycle implication
`define FSP_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("fsp assertion failed");

`endif

FILE: rtl/fsp_pkg.sv
package fsp_pkg;

  localparam int MAX_DIM   = 16384;
  localparam int DIM_W     = $clog2(MAX_DIM + 1);
  localparam int FIELD_W   = 15;
  localparam int FUNC_W    = 3;
  localparam int XY_W      = 28;
  localparam int WH_W      = 29;
  localparam int PROD_W    = 2 * DIM_W;
  localparam int CFG_IDX_W = 1;

  typedef logic [DIM_W-1:0]   dim_t;
  typedef logic [PROD_W-1:0]  prod_t;
  typedef logic [FIELD_W-1:0] field_t;

  // present method codes
  localparam logic [FUNC_W-1:0] FUNC_DEFAULT   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_CENTER    = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_ZOOM      = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_ZOOM_CROP = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_STRETCH   = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_HEIGHT = 1'd1;

  localparam field_t OUT_W_RESET = 15'd1920;
  localparam field_t OUT_H_RESET = 15'd1080;

  typedef enum logic [1:0] {
    KIND_CENTER,
    KIND_FIT,
    KIND_STRETCH,
    KIND_INVALID
  } kind_t;

  // per-item data riding alongside the divider
  typedef struct packed {
    kind_t kind;
    logic  crop;
    logic  fit_width;
    dim_t  ow;
    dim_t  oh;
    dim_t  sw;
    dim_t  sh;
  } side_t;

  function automatic dim_t clamp_dim(field_t v);
    if (v == '0) begin
      return dim_t'(1);
    end else if (int'(v) > MAX_DIM) begin
      return dim_t'(MAX_DIM);
    end else begin
      return dim_t'(v);
    end
  endfunction

  // signed halving that truncates toward zero
  function automatic logic signed [PROD_W:0] half_tz(logic signed [PROD_W:0] v);
    return (v + $signed({{PROD_W{1'b0}}, v[PROD_W]})) >>> 1;
  endfunction

endpackage

FILE: rtl/fsp_in_if.sv
interface fsp_in_if import fsp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [FIELD_W-1:0]  surface_width;
  logic [FIELD_W-1:0]  surface_height;

  modport source (output valid, func, surface_width, surface_height, input ready);
  modport sink   (input valid, func, surface_width, surface_height, output ready);
endinterface

FILE: rtl/fsp_out_if.sv
interface fsp_out_if import fsp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [XY_W-1:0]  place_x;
  logic signed [XY_W-1:0]  place_y;
  logic [WH_W-1:0]         place_width;
  logic [WH_W-1:0]         place_height;
  logic                    status;

  modport source (output valid, place_x, place_y, place_width, place_height, status,
                  input ready);
  modport sink   (input valid, place_x, place_y, place_width, place_height, status,
                  output ready);
endinterface

FILE: rtl/fullscreen_surface_placement.sv
// fullscreen surface placement: letterbox, crop and stretch fit
//
// in_ch carries one beat per request: present method and surface size.
// out_ch returns one beat per request: placement rectangle and status.
// cfg_we/cfg_idx/cfg_wdata write the output mode width (index 0) and
// height (index 1); change them only while the pipeline is empty.
//
// from accept to result a beat passes one clamp and multiply stage, one
// aspect compare stage, one stage per quotient bit in the restoring
// divider, and the output register; the divider chain sets the depth.
// throughput is one beat per cycle while no waiting result is held off.
//
// reset empties every stage and loads 1920 x 1080 into the output size.
// when the receiver holds off a waiting result the whole pipeline freezes
// and in_ch.ready drops, so nothing is dropped or sent twice; a bubble at
// the output lets the pipe keep moving even while out_ch.ready is low.
module fullscreen_surface_placement import fsp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  fsp_in_if.sink               in_ch,
  fsp_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [FIELD_W-1:0]   cfg_wdata
);

  // configuration
  field_t out_w_r, out_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_w_r <= OUT_W_RESET;
      out_h_r <= OUT_H_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_OUTPUT_WIDTH:  out_w_r <= cfg_wdata;
        CFG_OUTPUT_HEIGHT: out_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // global advance: move whenever the output slot is free or being taken
  logic out_valid_r;
  logic ce;

  assign ce          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = ce;

  // stage 1: clamp, classify, cross products
  side_t side1_nxt;
  logic  v1_r;
  side_t side1_r;
  prod_t prod_a_r, prod_b_r;   // ow*sh and oh*sw

  always_comb begin
    side1_nxt           = '0;
    side1_nxt.ow        = clamp_dim(out_w_r);
    side1_nxt.oh        = clamp_dim(out_h_r);
    side1_nxt.sw        = clamp_dim(in_ch.surface_width);
    side1_nxt.sh        = clamp_dim(in_ch.surface_height);
    case (in_ch.func)
      FUNC_DEFAULT, FUNC_CENTER: side1_nxt.kind = KIND_CENTER;
      FUNC_ZOOM:                 side1_nxt.kind = KIND_FIT;
      FUNC_ZOOM_CROP: begin
        side1_nxt.kind = KIND_FIT;
        side1_nxt.crop = 1'b1;
      end
      FUNC_STRETCH:              side1_nxt.kind = KIND_STRETCH;
      default:                   side1_nxt.kind = KIND_INVALID;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (ce) begin
      v1_r <= in_ch.valid && in_ch.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      side1_r  <= side1_nxt;
      prod_a_r <= side1_nxt.ow * side1_nxt.sh;
      prod_b_r <= side1_nxt.oh * side1_nxt.sw;
    end
  end

  // stage 2: aspect decision, pick dividend and divisor
  logic  v2_r;
  side_t side2_nxt;
  side_t side2_r;
  prod_t num2_r;
  dim_t  den2_r;
  logic  fit_w;

  // zoom fits the width when the output is relatively narrower, crop the reverse
  assign fit_w = side1_r.crop ? (prod_a_r >= prod_b_r) : (prod_a_r <= prod_b_r);

  always_comb begin
    side2_nxt           = side1_r;
    side2_nxt.fit_width = fit_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (ce) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      side2_r <= side2_nxt;
      num2_r  <= fit_w ? prod_a_r : prod_b_r;
      den2_r  <= fit_w ? side1_r.sw : side1_r.sh;
    end
  end

  // divider chain
  logic  v3;
  prod_t quot;
  side_t side3;

  fsp_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (v2_r),
    .in_num    (num2_r),
    .in_den    (den2_r),
    .in_side   (side2_r),
    .out_valid (v3),
    .out_quot  (quot),
    .out_side  (side3)
  );

  // final stage: offsets and result register
  logic signed [PROD_W:0] ow_s, oh_s, sw_s, sh_s, q_s, dx, dy;
  logic signed [XY_W-1:0] x_nxt, y_nxt;
  logic [WH_W-1:0]        w_nxt, h_nxt;
  logic                   st_nxt;

  logic signed [XY_W-1:0] x_r, y_r;
  logic [WH_W-1:0]        w_r, h_r;
  logic                   st_r;

  always_comb begin
    ow_s   = $signed({{(PROD_W+1-DIM_W){1'b0}}, side3.ow});
    oh_s   = $signed({{(PROD_W+1-DIM_W){1'b0}}, side3.oh});
    sw_s   = $signed({{(PROD_W+1-DIM_W){1'b0}}, side3.sw});
    sh_s   = $signed({{(PROD_W+1-DIM_W){1'b0}}, side3.sh});
    q_s    = $signed({1'b0, quot});
    dx     = '0;
    dy     = '0;
    w_nxt  = '0;
    h_nxt  = '0;
    st_nxt = 1'b0;
    case (side3.kind)
      KIND_CENTER: begin
        dx    = ow_s - sw_s;
        dy    = oh_s - sh_s;
        w_nxt = WH_W'(side3.sw);
        h_nxt = WH_W'(side3.sh);
      end
      KIND_FIT: begin
        if (side3.fit_width) begin
          dy    = oh_s - q_s;
          w_nxt = WH_W'(side3.ow);
          h_nxt = WH_W'(quot);
        end else begin
          dx    = ow_s - q_s;
          w_nxt = WH_W'(quot);
          h_nxt = WH_W'(side3.oh);
        end
      end
      KIND_STRETCH: begin
        w_nxt = WH_W'(side3.ow);
        h_nxt = WH_W'(side3.oh);
      end
      default: st_nxt = 1'b1;
    endcase
    x_nxt = XY_W'(half_tz(dx));
    y_nxt = XY_W'(half_tz(dy));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ce) begin
      out_valid_r <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      x_r  <= x_nxt;
      y_r  <= y_nxt;
      w_r  <= w_nxt;
      h_r  <= h_nxt;
      st_r <= st_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.place_x      = x_r;
  assign out_ch.place_y      = y_r;
  assign out_ch.place_width  = w_r;
  assign out_ch.place_height = h_r;
  assign out_ch.status       = st_r;

endmodule

FILE: rtl/fsp_divider.sv
module fsp_divider import fsp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  ce,
  input  logic  in_valid,
  input  prod_t in_num,
  input  dim_t  in_den,
  input  side_t in_side,
  output logic  out_valid,
  output prod_t out_quot,
  output side_t out_side
);

  // one quotient bit per stage, restoring
  localparam int STEPS = PROD_W;

  logic  v_r    [STEPS];
  dim_t  rem_r  [STEPS];
  prod_t q_r    [STEPS];
  dim_t  den_r  [STEPS];
  side_t side_r [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic         v_in;
    dim_t         rem_in;
    prod_t        q_in;
    dim_t         den_in;
    side_t        side_in;
    logic [DIM_W:0] trial;
    logic         take;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = '0;
      assign q_in    = in_num;
      assign den_in  = in_den;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign q_in    = q_r[k-1];
      assign den_in  = den_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign trial = {rem_in, q_in[PROD_W-1]};
    assign take  = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (ce) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem_r[k]  <= take ? DIM_W'(trial - {1'b0, den_in}) : DIM_W'(trial);
        q_r[k]    <= {q_in[PROD_W-2:0], take};
        den_r[k]  <= den_in;
        side_r[k] <= side_in;
      end
    end
  end

  assign out_valid = v_r[STEPS-1];
  assign out_quot  = q_r[STEPS-1];
  assign out_side  = side_r[STEPS-1];

endmodule

FILE: rtl/fsp_checker.sv
`include "fullscreen_surface_placement_defines.svh"

module fsp_checker import fsp_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic signed [XY_W-1:0] out_x,
  input logic signed [XY_W-1:0] out_y,
  input logic [WH_W-1:0]        out_w,
  input logic [WH_W-1:0]        out_h,
  input logic                   out_status
);

  // whole result beat, status in the low bit
  logic [2*XY_W+2*WH_W:0] beat_bits;

  assign beat_bits = {out_x, out_y, out_w, out_h, out_status};

  `FSP_ASSERT_NEXT(a_stall_hold, clk, !rst_n, out_valid && !out_ready, out_valid && $stable(beat_bits))
  `FSP_ASSERT_NOW(a_invalid_zero, clk, !rst_n, out_valid && out_status, beat_bits[2*XY_W+2*WH_W:1] == '0)
  `FSP_ASSERT_NOW(a_beat_known, clk, !rst_n, out_valid, !$isunknown(beat_bits))
  `FSP_ASSERT_NEXT(a_reset_empty, clk, 1'b0, !rst_n, !out_valid)

endmodule

bind fullscreen_surface_placement fsp_checker u_fsp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_x      (out_ch.place_x),
  .out_y      (out_ch.place_y),
  .out_w      (out_ch.place_width),
  .out_h      (out_ch.place_height),
  .out_status (out_ch.status)
);
